/* src/srj_pkg.sv */
package srj_pkg;

    localparam int WINDOW_DEF = 32;
    localparam int SEQ_W      = 32;
    localparam int PAY_W      = 64;

    typedef enum logic [2:0] {
        KIND_RELEASED  = 3'd0,
        KIND_STALE     = 3'd1,
        KIND_BEYOND    = 3'd2,
        KIND_DUPLICATE = 3'd3,
        KIND_CLOSED    = 3'd4
    } kind_t;

    // Source of the sequence number and payload of a result.
    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_DROP,
        SEL_SLOT,
        SEL_CLOSE
    } out_sel_t;

    typedef struct packed {
        logic     store;
        logic     rd_head;
        logic     advance;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     reset_window;
        logic     out_load;
        out_sel_t out_sel;
        kind_t    out_kind;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic is_end;
        logic ordered;
        logic in_window;
        logic stale;
        logic dup;
        logic at_head;
        logic head_valid;
        logic next_valid;
        logic cnt_last;
        logic out_free;
    } sts_t;

endpackage

/* src/srj_in_if.sv */
interface srj_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] sequence_req;
    logic [63:0] payload;

    modport source (output valid, output op, output sequence_req, output payload, input ready);
    modport sink (input valid, input op, input sequence_req, input payload, output ready);
endinterface

/* src/srj_out_if.sv */
interface srj_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] out_sequence;
    logic [63:0] out_payload;
    logic        last;

    modport source (output valid, output kind, output out_sequence, output out_payload,
                    output last, input ready);
    modport sink (input valid, input kind, input out_sequence, input out_payload,
                  input last, output ready);
endinterface

/* src/sequence_reorder_joiner_unit.sv */
// Channel    Dir  Payload                                       Transfer when
// decision   in   op, sequence_req[31:0], payload[63:0]         valid & ready
// result     out  kind[2:0], out_sequence[31:0],                valid & ready
//                 out_payload[63:0], last
// cfg        in   cfg_wr_data (ordered_mode)                    cfg_wr_en
//
// A pass-through decision or a dropped decision loads the result register in the
// accepting cycle; a decision stored ahead of a gap is written to its slot then.
// A release run reads each released decision out of the registered single-read
// slot memory and then loads it into the result register. End of stream scans all
// WINDOW slots, reads out each stored one and then loads the close marker.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result channel holds the result register and the controller waits.
module sequence_reorder_joiner_unit
    import srj_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    srj_in_if.sink    decision,
    srj_out_if.source result,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    // Commands from the controller and status back from the datapath.
    cmd_t  cmd;
    sts_t  sts;
    kind_t res_kind;

    // The controller sequences each transfer: it classifies accepted decisions,
    // walks the release run one slot at a time and sweeps the window at end of stream.
    srj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (decision.valid),
        .in_ready (decision.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the expected sequence, the head pointer, the slot valid
    // bits, the payload memory and the result register.
    srj_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_op        (decision.op),
        .in_sequence  (decision.sequence_req),
        .in_payload   (decision.payload),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_kind     (res_kind),
        .out_sequence (result.out_sequence),
        .out_payload  (result.out_payload),
        .out_last     (result.last),
        .cmd          (cmd),
        .sts          (sts)
    );

    assign result.kind = res_kind;

endmodule

/* src/srj_ram.sv */
module srj_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/srj_ctrl.sv */
module srj_ctrl
    import srj_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL_RD,
        ST_REL_OUT,
        ST_DRAIN,
        ST_DR_OUT,
        ST_CLOSE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.out_sel  = SEL_INPUT;
        cmd.out_kind = KIND_RELEASED;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_DRAIN;
                    end
                    else if (!sts.ordered)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_INPUT;
                        cmd.out_kind = KIND_RELEASED;
                        cmd.out_last = 1'b1;
                    end
                    else if (!sts.in_window)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_DROP;
                        if (sts.stale)
                        begin
                            cmd.out_kind = KIND_STALE;
                        end
                        else
                        begin
                            cmd.out_kind = KIND_BEYOND;
                        end
                        cmd.out_last = 1'b1;
                    end
                    else if (sts.dup)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_DROP;
                        cmd.out_kind = KIND_DUPLICATE;
                        cmd.out_last = 1'b1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (sts.at_head)
                        begin
                            state_next = ST_REL_RD;
                        end
                    end
                end
            end
            ST_REL_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = ST_REL_OUT;
            end
            ST_REL_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_SLOT;
                    cmd.out_kind = KIND_RELEASED;
                    cmd.out_last = !sts.next_valid;
                    cmd.advance  = 1'b1;
                    state_next   = sts.next_valid ? ST_REL_RD : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (sts.head_valid)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_DR_OUT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.cnt_inc = !sts.cnt_last;
                    state_next  = sts.cnt_last ? ST_CLOSE : ST_DRAIN;
                end
            end
            ST_DR_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_SLOT;
                    cmd.out_kind = KIND_RELEASED;
                    cmd.advance  = 1'b1;
                    cmd.cnt_inc  = !sts.cnt_last;
                    state_next   = sts.cnt_last ? ST_CLOSE : ST_DRAIN;
                end
            end
            ST_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = SEL_CLOSE;
                    cmd.out_kind     = KIND_CLOSED;
                    cmd.out_last     = 1'b1;
                    cmd.reset_window = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/srj_dp.sv */
module srj_dp
    import srj_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             in_op,
    input  logic [SEQ_W-1:0] in_sequence,
    input  logic [PAY_W-1:0] in_payload,
    input  logic             out_ready,
    output logic             out_valid,
    output kind_t            out_kind,
    output logic [SEQ_W-1:0] out_sequence,
    output logic [PAY_W-1:0] out_payload,
    output logic             out_last,
    input  cmd_t             cmd,
    output sts_t             sts
);

    localparam int IW = $clog2(WINDOW);

    logic              ordered_reg;
    logic [SEQ_W-1:0]  expected_reg;
    logic [SEQ_W-1:0]  expected_next;
    logic [IW-1:0]     head_reg;
    logic [IW-1:0]     head_next;
    logic [IW-1:0]     head_inc;
    logic [WINDOW-1:0] valid_reg;
    logic [WINDOW-1:0] valid_next;
    logic [IW-1:0]     cnt_reg;
    logic [IW-1:0]     cnt_next;
    logic [SEQ_W-1:0]  seq_gap;
    logic [IW:0]       idx_sum;
    logic [IW-1:0]     idx;
    logic [PAY_W-1:0]  rd_data;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [PAY_W-1:0]  out_pay_reg;
    logic              out_last_reg;

    // Distance from the expected sequence, and the slot it maps to.
    assign seq_gap  = in_sequence - expected_reg;
    assign idx_sum  = {1'b0, head_reg} + {1'b0, seq_gap[IW-1:0]};
    assign idx      = (idx_sum >= (IW+1)'(WINDOW)) ? IW'(idx_sum - (IW+1)'(WINDOW))
                                                   : idx_sum[IW-1:0];
    assign head_inc = (head_reg == IW'(WINDOW - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        sts.is_end     = in_op;
        sts.ordered    = ordered_reg;
        sts.in_window  = seq_gap < SEQ_W'(WINDOW);
        sts.stale      = seq_gap[SEQ_W-1];
        sts.dup        = sts.in_window && valid_reg[idx];
        sts.at_head    = seq_gap == '0;
        sts.head_valid = valid_reg[head_reg];
        sts.next_valid = valid_reg[head_inc];
        sts.cnt_last   = cnt_reg == IW'(WINDOW - 1);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    srj_ram #(
        .WIDTH (PAY_W),
        .DEPTH (WINDOW)
    ) u_slots (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (idx),
        .wr_data (in_payload),
        .rd_en   (cmd.rd_head),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        valid_next    = valid_reg;
        head_next     = head_reg;
        expected_next = expected_reg;
        cnt_next      = cnt_reg;
        if (cmd.store)
        begin
            valid_next[idx] = 1'b1;
        end
        if (cmd.advance)
        begin
            valid_next[head_reg] = 1'b0;
            head_next            = head_inc;
            expected_next        = expected_reg + 1'b1;
        end
        if (cmd.reset_window)
        begin
            valid_next    = '0;
            head_next     = '0;
            expected_next = '0;
        end
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_reg   <= 1'b0;
            expected_reg  <= '0;
            head_reg      <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ordered_reg <= cfg_wr_data;
            end
            expected_reg <= expected_next;
            head_reg     <= head_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_last_reg <= cmd.out_last;
            case (cmd.out_sel)
                SEL_INPUT:
                begin
                    out_seq_reg <= in_sequence;
                    out_pay_reg <= in_payload;
                end
                SEL_DROP:
                begin
                    out_seq_reg <= in_sequence;
                    out_pay_reg <= '0;
                end
                SEL_SLOT:
                begin
                    out_seq_reg <= expected_reg;
                    out_pay_reg <= rd_data;
                end
                default:
                begin
                    out_seq_reg <= '0;
                    out_pay_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_sequence = out_seq_reg;
    assign out_payload  = out_pay_reg;
    assign out_last     = out_last_reg;

endmodule

/* dv/joiner_tb_pkg.sv */
`timescale 1ns / 100ps
package joiner_tb_pkg;
    import srj_pkg::*;

    localparam int WIN = WINDOW_DEF;

    localparam logic OP_DECISION  = 1'b0;
    localparam logic OP_END       = 1'b1;
    localparam logic MODE_PASS    = 1'b0;
    localparam logic MODE_ORDERED = 1'b1;

    typedef struct {
        kind_t            kind;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] pay;
        logic             last;
    } result_t;

    // Tracks the window contents and the queue of results still owed by the block.
    class release_scoreboard;
        logic             ordered;
        logic [SEQ_W-1:0] next_seq;
        logic             slot_full [WIN];
        logic [PAY_W-1:0] slot_data [WIN];
        int unsigned      head_slot;
        result_t          awaited [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      released;
        int unsigned      dropped;
        int unsigned      closes;
        int unsigned      longest;

        function new();
            ordered  = MODE_PASS;
            errors   = 0;
            checked  = 0;
            released = 0;
            dropped  = 0;
            closes   = 0;
            longest  = 0;
            clear_window();
        endfunction

        function void clear_window();
            for (int i = 0; i < WIN; i++)
            begin
                slot_full[i] = 1'b0;
                slot_data[i] = '0;
            end
            head_slot = 0;
            next_seq  = '0;
        endfunction

        function void owe(kind_t k, logic [SEQ_W-1:0] s, logic [PAY_W-1:0] p);
            result_t r;
            r.kind = k;
            r.seq  = s;
            r.pay  = p;
            r.last = 1'b0;
            awaited.push_back(r);
        endfunction

        // Called once per accepted input transfer.
        function void note_decision(logic op, logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
            result_t          r;
            logic [SEQ_W-1:0] seq_gap;
            int unsigned      idx;
            int unsigned      n;
            n = 0;
            if (op == OP_END)
            begin
                for (int d = 0; d < WIN; d++)
                begin
                    idx = (head_slot + d) % WIN;
                    if (slot_full[idx])
                    begin
                        owe(KIND_RELEASED, next_seq + d, slot_data[idx]);
                        n++;
                    end
                end
                owe(KIND_CLOSED, '0, '0);
                n++;
                clear_window();
            end
            else if (ordered == MODE_PASS)
            begin
                owe(KIND_RELEASED, seq, pay);
                n++;
            end
            else
            begin
                seq_gap = seq - next_seq;
                if (seq_gap >= WIN)
                begin
                    if (seq_gap[SEQ_W-1])
                        owe(KIND_STALE, seq, '0);
                    else
                        owe(KIND_BEYOND, seq, '0);
                    n++;
                end
                else
                begin
                    idx = (head_slot + seq_gap) % WIN;
                    if (slot_full[idx])
                    begin
                        owe(KIND_DUPLICATE, seq, '0);
                        n++;
                    end
                    else
                    begin
                        slot_full[idx] = 1'b1;
                        slot_data[idx] = pay;
                        while (slot_full[head_slot])
                        begin
                            owe(KIND_RELEASED, next_seq, slot_data[head_slot]);
                            n++;
                            slot_full[head_slot] = 1'b0;
                            slot_data[head_slot] = '0;
                            head_slot = (head_slot + 1) % WIN;
                            next_seq  = next_seq + 1;
                        end
                    end
                end
            end
            if (n > 0)
            begin
                r = awaited.pop_back();
                r.last = 1'b1;
                awaited.push_back(r);
            end
            if (n > longest)
                longest = n;
        endfunction

        function void check_result(logic [2:0] kind, logic [SEQ_W-1:0] seq,
                                   logic [PAY_W-1:0] pay, logic last);
            result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d, out_sequence %0h", kind, seq);
                errors++;
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    errors++;
                end
                if (seq !== want.seq)
                begin
                    $error("out_sequence mismatch: expected %0h, actual %0h", want.seq, seq);
                    errors++;
                end
                if (pay !== want.pay)
                begin
                    $error("out_payload mismatch: expected %0h, actual %0h", want.pay, pay);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, last);
                    errors++;
                end
                case (want.kind)
                    KIND_RELEASED: released++;
                    KIND_CLOSED:   closes++;
                    default:       dropped++;
                endcase
            end
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
    import srj_pkg::*;
    import joiner_tb_pkg::*;

    // Stimulus volume and timing bounds. The settle pause is sized to cover the
    // end-of-stream drain of a completely full window.
    localparam int unsigned TOTAL_ITEMS   = 330;
    localparam int unsigned QUIET_FROM    = TOTAL_ITEMS - 40;
    localparam int unsigned SETTLE_CYCLES = 2 * WIN + 8;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned STALL_LIMIT   = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    srj_in_if  decision_if ();
    srj_out_if result_if ();

    sequence_reorder_joiner_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .decision    (decision_if),
        .result      (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    release_scoreboard sb = new();

    // Shared flags between the sender and the receiver. Random idling is switched
    // off for the tail of the run so the block also sees back-to-back traffic.
    bit          idle_on   = 1'b1;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned items_sent   = 0;
    int unsigned mode_changes = 0;

    function automatic logic [PAY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one item and returns at the edge where the transfer happens. A random
    // gap with valid low may be inserted first.
    task automatic send_item(input logic op, input logic [SEQ_W-1:0] seq,
                             input logic [PAY_W-1:0] pay);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            decision_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        decision_if.valid        <= 1'b1;
        decision_if.op           <= op;
        decision_if.sequence_req <= seq;
        decision_if.payload      <= pay;
        do @(posedge clk); while (decision_if.ready !== 1'b1);
        sb.note_decision(op, seq, pay);
        items_sent++;
        idle_on = (items_sent < QUIET_FROM);
    endtask

    task automatic send_decision(input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] pay);
        send_item(OP_DECISION, seq, pay);
    endtask

    // The end marker ignores its other fields, so they carry random values.
    task automatic send_end();
        send_item(OP_END, $urandom, rand64());
    endtask

    // The mode register is only written while the block is quiet: every owed result
    // has arrived, and a stored-only item or a drain scan has had time to finish.
    task automatic write_mode(input logic mode);
        decision_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.ordered = mode;
        mode_changes++;
    endtask

    // An out-of-place decision: stale, beyond the window, anywhere in the window
    // (which may store, duplicate or even release), or a fully random number.
    task automatic send_noise();
        logic [SEQ_W-1:0] s;
        case ($urandom_range(0, 3))
            0:       s = $urandom;
            1:       s = sb.next_seq - $urandom_range(1, 3);
            2:       s = sb.next_seq + $urandom_range(WIN, WIN + 4);
            default: s = sb.next_seq + $urandom_range(0, WIN - 1);
        endcase
        send_decision(s, rand64());
    endtask

    // One well-formed ordered sequence: a shuffled run starting at the sequence the
    // block waits for. Sometimes one entry is left out, which leaves stored entries
    // behind a gap; those are usually flushed by an end marker. A full-window block
    // has no noise so that it yields the longest release run or the longest drain.
    task automatic ordered_block(input bit full_window, input bit head_gap);
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] tmp;
        int unsigned      len;
        int unsigned      j;
        bit               leave_gap;
        base = sb.next_seq;
        if (full_window)
            len = WIN;
        else
            len = ($urandom_range(0, 3) == 0) ? WIN : $urandom_range(1, 12);
        order = {};
        for (int i = 0; i < len; i++)
            order.push_back(base + i);
        for (int i = len - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        leave_gap = head_gap || ((len > 1) && ($urandom_range(0, 3) == 0));
        if (leave_gap)
        begin
            if (head_gap || $urandom_range(0, 1) == 0)
            begin
                foreach (order[k])
                    if (order[k] == base)
                        j = k;
            end
            else
                j = $urandom_range(0, len - 1);
            order.delete(j);
        end
        foreach (order[i])
        begin
            if (!full_window && $urandom_range(0, 7) == 0)
                send_noise();
            send_decision(order[i], rand64());
        end
        if (head_gap || $urandom_range(0, leave_gap ? 1 : 4) == 0)
            send_end();
    endtask

    // Pass-through traffic with full-range fields. The first such phase also asks
    // the receiver for its long hold-off, so the block backs up and stalls its input.
    task automatic pass_phase();
        if (!hold_done)
            hold_req = 1'b1;
        repeat ($urandom_range(20, 40))
        begin
            if ($urandom_range(0, 11) == 0)
                send_end();
            else
                send_decision($urandom, rand64());
        end
    endtask

    // Result receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // Every result transfer is checked against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            sb.check_result(result_if.kind, result_if.out_sequence,
                            result_if.out_payload, result_if.last);
    end

    // Watchdog: too many cycles in a row without a transfer on either side ends
    // the run as a failure.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((decision_if.valid === 1'b1 && decision_if.ready === 1'b1) ||
                (result_if.valid === 1'b1 && result_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("** sequence_reorder_joiner_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic mode;
        rst_n                    <= 1'b0;
        cfg_wr_en                <= 1'b0;
        cfg_wr_data              <= MODE_PASS;
        decision_if.valid        <= 1'b0;
        decision_if.op           <= OP_DECISION;
        decision_if.sequence_req <= '0;
        decision_if.payload      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Pass-through with the field extremes, and a close with
        // nothing stored.
        write_mode(MODE_PASS);
        send_decision('0, '0);
        send_decision('1, '1);
        send_end();

        // Ordered mode from a fresh window: an in-order release, entries stored
        // ahead of a gap, a duplicate of a stored entry, a release run that closes
        // the gap, then a stale entry just behind, the last in-window slot, the
        // first slot beyond it, and both sides of the stale/beyond boundary.
        write_mode(MODE_ORDERED);
        send_decision(32'd0, rand64());
        send_decision(32'd2, rand64());
        send_decision(32'd3, '1);
        send_decision(32'd2, rand64());
        send_decision(32'd1, '0);
        send_decision(32'd0, rand64());
        send_decision(32'd35, rand64());
        send_decision(32'd36, rand64());
        send_decision(32'd4 + 32'h7FFF_FFFF, rand64());
        send_decision(32'd4 + 32'h8000_0000, rand64());
        send_decision(32'd35, rand64());
        send_decision(32'd9, rand64());

        // Entries are still stored when the mode drops to pass-through. They must
        // stay put until the end marker drains them, gaps included.
        write_mode(MODE_PASS);
        send_decision(32'd5, rand64());
        send_end();

        // Fresh stream again: wrap-around stale, the exact boundary, and a lone
        // entry in the highest slot drained at the end.
        write_mode(MODE_ORDERED);
        send_decision(32'hFFFF_FFFF, rand64());
        send_decision(32'h8000_0000, rand64());
        send_decision(32'h7FFF_FFFF, rand64());
        send_decision(32'd31, rand64());
        send_end();

        // Random part. The first ordered phase opens with a full-window release
        // run and a full-window drain behind a missing head.
        ordered_block(1'b1, 1'b0);
        ordered_block(1'b1, 1'b1);
        mode = MODE_PASS;
        while (items_sent < TOTAL_ITEMS)
        begin
            write_mode(mode);
            if (mode == MODE_ORDERED)
            begin
                repeat ($urandom_range(4, 8))
                    if (items_sent < TOTAL_ITEMS)
                        ordered_block(1'b0, 1'b0);
            end
            else
                pass_phase();
            mode = ~mode;
        end

        decision_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d inputs and %0d results (%0d released, %0d dropped, %0d closes).",
                 items_sent, sb.checked, sb.released, sb.dropped, sb.closes);
        $display("Mode writes: %0d; most results from a single input: %0d.",
                 mode_changes, sb.longest);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("** sequence_reorder_joiner_unit: PASSED **");
        else
            $display("** sequence_reorder_joiner_unit: FAILED **");
        $finish;
    end

endmodule
